FILE: rtl/core/stt_pkg.sv
`default_nettype none
package stt_pkg;
	localparam int unsigned TableEntries = 16;
	localparam int unsigned SlotW = $clog2(TableEntries);
	localparam logic [62:0] TimeMax = {63{1'b1}};
	localparam logic [30:0] WaitMax = {31{1'b1}};
	localparam logic [30:0] IdleTtlRst = 31'd3600000;
	localparam logic [15:0] MinYieldRst = 16'd100;
	localparam logic [0:0] RegIdleTtl = 1'b0;
	localparam logic [0:0] RegMinYield = 1'b1;
	localparam logic OpWatch = 1'b0;
	localparam logic OpTick = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [62:0] now_time;
		logic [31:0] session_key;
		logic [31:0] timeout_ms;
	} in_beat_t;

	typedef struct packed {
		logic        expired_valid;
		logic [31:0] expired_key;
		logic        last;
		logic [62:0] next_wakeup;
		logic [30:0] wait_ms;
		logic        wake_request;
		logic        status;
	} out_beat_t;

	// token passed along the cell chain
	typedef struct packed {
		logic        op;
		logic [62:0] now;
		logic [31:0] key;
		logic [62:0] expiry;
		logic        hit;
		logic        have_free;
		logic [SlotW-1:0] free_slot;
	} tok_t;
endpackage
`default_nettype wire

FILE: rtl/core/stt_cell.sv
`default_nettype none
module stt_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic [stt_pkg::SlotW-1:0] my_slot,
	input  wire stt_pkg::tok_t         tok_in,
	input  wire logic                  wr_free,
	output stt_pkg::tok_t              tok_out,
	output logic                       used,
	output logic [31:0]                key,
	output logic [62:0]                expiry,
	output logic                       expire
);
	logic        used_q;
	logic [31:0] key_q;
	logic [62:0] exp_q;
	logic        match;

	assign used = used_q;
	assign key = key_q;
	assign expiry = exp_q;
	assign match = used_q && key_q == tok_in.key;
	assign expire = tok_in.op == stt_pkg::OpTick && used_q && exp_q <= tok_in.now;

	always_comb begin
		tok_out = tok_in;
		if (tok_in.op == stt_pkg::OpWatch) begin
			if (!tok_in.hit && match) begin
				tok_out.hit = 1'b1;
				tok_out.free_slot = my_slot;
			end else if (!tok_in.hit && !tok_in.have_free && !used_q) begin
				tok_out.have_free = 1'b1;
				tok_out.free_slot = my_slot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (en) begin
			if (expire) used_q <= 1'b0;
			else if (wr_free) used_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && wr_free) begin
			key_q <= tok_in.key;
			exp_q <= tok_in.expiry;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/session_timeout_table_top.sv
`default_nettype none
// Channel | Dir | Handshake         | Payload
// in      | in  | in_valid/ready    | stt_pkg::in_beat_t
// out     | out | out_valid/ready   | stt_pkg::out_beat_t
// cfg     | in  | cfg_valid/ready   | cfg_index, cfg_data
// A watch visits the cells one per cycle to find the slot (S_SCAN), then writes
// it (S_WRITE) if a match or free slot was found, then gives the result beat.
// A tick visits one cell per cycle, but stops to give each expired beat that is
// not the last one until out takes it; after the scan S_FIN gives the last beat.
// One item at a time. Reset clears all used bits and sets wake_q to TimeMax.
module session_timeout_table_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire stt_pkg::in_beat_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output stt_pkg::out_beat_t      out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	localparam int unsigned N = stt_pkg::TableEntries;
	localparam int unsigned W = stt_pkg::SlotW;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WRITE, S_FIN, S_OUT} st_t;
	st_t st_q;

	stt_pkg::tok_t tok_q;
	stt_pkg::tok_t tok_chain [N];
	logic [W-1:0] idx_q;
	logic [30:0] ttl_q;
	logic [15:0] yield_q;
	logic [62:0] nw_q;
	logic [62:0] wake_q;
	logic any_q;
	logic [N-1:0] used_v, exp_v, wr_v, en_v;
	logic [31:0] key_v [N];
	logic [62:0] expy_v [N];
	stt_pkg::out_beat_t ob_q;
	logic [63:0] sum;
	logic [62:0] diff;
	logic [62:0] w1;
	logic later_exp;

	assign in_ready = st_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = st_q == S_OUT;
	assign out_data = ob_q;

	// every cell sees tok_q; only the output of the cell at idx_q is taken
	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			assign en_v[g] = st_q == S_SCAN && idx_q == W'(g) || st_q == S_WRITE;
			assign wr_v[g] = st_q == S_WRITE && tok_q.free_slot == W'(g) &&
				(tok_q.hit || tok_q.have_free);
			stt_cell u_cell (
				.clk(clk), .arst_n(arst_n),
				.en(en_v[g] && (st_q == S_WRITE || tok_q.op == stt_pkg::OpTick)),
				.my_slot(W'(g)), .tok_in(tok_q), .wr_free(wr_v[g]),
				.tok_out(tok_chain[g]), .used(used_v[g]), .key(key_v[g]),
				.expiry(expy_v[g]), .expire(exp_v[g]));
		end
	endgenerate

	logic wr_ok;
	assign wr_ok = tok_q.hit || tok_q.have_free;
	assign sum = {1'b0, in_data.now_time} + {33'd0, ttl_q};
	assign diff = nw_q - tok_q.now;
	assign w1 = diff < {47'd0, yield_q} ? {47'd0, yield_q} : diff;
	assign later_exp = |((exp_v >> idx_q) >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			wake_q <= stt_pkg::TimeMax;
			ttl_q <= stt_pkg::IdleTtlRst;
			yield_q <= stt_pkg::MinYieldRst;
			idx_q <= '0;
			any_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					stt_pkg::RegIdleTtl:  ttl_q <= cfg_data[30:0];
					stt_pkg::RegMinYield: yield_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			unique case (st_q)
				S_IDLE: if (in_valid) begin
					idx_q <= '0;
					any_q <= 1'b0;
					st_q <= S_SCAN;
				end
				S_SCAN: begin
					if (tok_q.op == stt_pkg::OpTick && exp_v[idx_q]) any_q <= 1'b1;
					if (tok_q.op == stt_pkg::OpTick && exp_v[idx_q] && later_exp) begin
						st_q <= S_OUT;
					end else if (idx_q == W'(N-1)) begin
						st_q <= tok_q.op == stt_pkg::OpTick ? S_FIN : S_WRITE;
					end else idx_q <= idx_q + 1'b1;
				end
				S_WRITE: st_q <= S_OUT;
				S_FIN: begin
					wake_q <= nw_q;
					st_q <= S_OUT;
				end
				S_OUT: if (out_ready) begin
					if (ob_q.last) st_q <= S_IDLE;
					else if (idx_q == W'(N-1)) st_q <= S_FIN;
					else begin
						idx_q <= idx_q + 1'b1;
						st_q <= S_SCAN;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && in_valid) begin
			tok_q.op <= in_data.opcode;
			tok_q.now <= in_data.now_time;
			tok_q.key <= in_data.session_key;
			tok_q.hit <= 1'b0;
			tok_q.have_free <= 1'b0;
			tok_q.free_slot <= '0;
			begin
				logic [63:0] e;
				e = {1'b0, in_data.now_time} +
					(in_data.timeout_ms[31] ? 64'd0 : {32'd0, in_data.timeout_ms});
				tok_q.expiry <= e[63] ? stt_pkg::TimeMax : e[62:0];
			end
			nw_q <= sum[63] ? stt_pkg::TimeMax : sum[62:0];
		end else if (st_q == S_SCAN) begin
			if (tok_q.op == stt_pkg::OpWatch) begin
				tok_q.hit <= tok_chain[idx_q].hit;
				tok_q.have_free <= tok_chain[idx_q].have_free;
				tok_q.free_slot <= tok_chain[idx_q].free_slot;
			end else if (exp_v[idx_q]) begin
				ob_q <= '{1'b1, key_v[idx_q], 1'b0, 63'd0, 31'd0, 1'b0, 1'b0};
			end else if (used_v[idx_q] && expy_v[idx_q] < nw_q) begin
				nw_q <= expy_v[idx_q];
			end
		end else if (st_q == S_WRITE) begin
			ob_q <= '{1'b0, 32'd0, 1'b1, wake_q, 31'd0,
				wr_ok && tok_q.expiry < wake_q, !wr_ok};
		end else if (st_q == S_FIN) begin
			if (any_q) begin
				ob_q.last <= 1'b1;
				ob_q.next_wakeup <= nw_q;
				ob_q.wait_ms <= w1[62:31] != '0 ? stt_pkg::WaitMax : w1[30:0];
			end else begin
				ob_q <= '{1'b0, 32'd0, 1'b1, nw_q,
					w1[62:31] != '0 ? stt_pkg::WaitMax : w1[30:0], 1'b0, 1'b0};
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("out beat changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_WRITE |-> $countones(wr_v) <= 1)
		else $error("multiple slots written");
endmodule
`default_nettype wire
